/* rtl/pcc_pkg.sv */
package pcc_pkg;

    // field widths of one transaction
    localparam int FUNC_W = 3;
    localparam int VAL_W  = 32;
    localparam int ANG_W  = 19;

    // parameter defaults
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_SHIFT      = 3'd0;
    localparam logic [FUNC_W-1:0] OP_ROTATE     = 3'd1;
    localparam logic [FUNC_W-1:0] OP_TO_POLAR   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_FROM_POLAR = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DISTANCE   = 3'd4;

    // fixed-point constants, angles in Q30
    localparam int    GUARD_BITS   = 8;
    localparam int    GAIN_W       = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;
    localparam longint HALF_PI_Q30  = 1686629713;
    localparam longint QUARTER_ROUND = HALF_PI_Q30 / 2;

    // coordinate datapath width: difference scaled by the guard bits plus cordic growth
    localparam int XW = 44;

    // gain multiply split point and final shift
    localparam int FIN_SPLIT = 21;
    localparam int FIN_SHIFT = 30 + GUARD_BITS - FIN_SPLIT;

    // width of a scaled result before clamping
    localparam int CLAMP_W = 38;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'h3243F6A8;
            1:  v = 30'h1DAC6705;
            2:  v = 30'h0FADBAFC;
            3:  v = 30'h07F56EA6;
            4:  v = 30'h03FEAB76;
            5:  v = 30'h01FFD55B;
            6:  v = 30'h00FFFAAA;
            7:  v = 30'h007FFF55;
            8:  v = 30'h003FFFEA;
            9:  v = 30'h001FFFFD;
            10: v = 30'h000FFFFF;
            11: v = 30'h0007FFFF;
            12: v = 30'h0003FFFF;
            13: v = 30'h0001FFFF;
            14: v = 30'h0000FFFF;
            15: v = 30'h00007FFF;
            16: v = 30'h00003FFF;
            17: v = 30'h00001FFF;
            18: v = 30'h00000FFF;
            19: v = 30'h000007FF;
            20: v = 30'h000003FF;
            21: v = 30'h000001FF;
            22: v = 30'h000000FF;
            23: v = 30'h0000007F;
            24: v = 30'h0000003F;
            25: v = 30'h0000001F;
            26: v = 30'h0000000F;
            27: v = 30'h00000008;
            28: v = 30'h00000004;
            29: v = 30'h00000002;
            30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range, msb of the result is the saturation flag
    function automatic logic [VAL_W:0] clamp_val(input logic signed [CLAMP_W-1:0] v);
        logic [VAL_W:0] r;
        if (v[CLAMP_W-1:VAL_W-1] == '0 || v[CLAMP_W-1:VAL_W-1] == '1)
        begin
            r = {1'b0, v[VAL_W-1:0]};
        end
        else if (v[CLAMP_W-1])
        begin
            r = {1'b1, 1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b1, 1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* rtl/pcc_if.sv */
interface pcc_in_if;
    import pcc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [VAL_W-1:0]  a_x;
    logic signed [VAL_W-1:0]  a_y;
    logic signed [VAL_W-1:0]  b_x;
    logic signed [VAL_W-1:0]  b_y;
    logic signed [ANG_W-1:0]  turn_angle;

    modport source (output valid, func, a_x, a_y, b_x, b_y, turn_angle, input ready);
    modport sink   (input valid, func, a_x, a_y, b_x, b_y, turn_angle, output ready);
endinterface

interface pcc_out_if;
    import pcc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic                     saturated;

    modport source (output valid, out_x, out_y, saturated, input ready);
    modport sink   (input valid, out_x, out_y, saturated, output ready);
endinterface

/* rtl/planar_coordinate_cordic.sv */
// Planar point unit: shift, rotate, to-polar, from-polar and distance on signed
// Q16.16 points through one fully unrolled CORDIC pipeline. A transaction is taken
// every cycle while the result side keeps up, and each one gives exactly one result,
// in order. A transaction passes an input stage, QB quarter-turn reduction steps
// for the angle (19 - FRACTION_BITS, at least 1), a setup stage, the rotations,
// a gain stage and the output register. The whole pipeline advances together; when
// a result waits in the output register and the sink does not take it, the pipeline
// holds and no new transaction is taken until it moves on.
module planar_coordinate_cordic #(
    parameter int CORDIC_STAGES = pcc_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = pcc_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcc_in_if.sink      item,
    pcc_out_if.source   result
);
    import pcc_pkg::*;

    localparam int ANG_SH = 30 - FRACTION_BITS;
    localparam int ZW     = (50 - FRACTION_BITS > 34) ? 50 - FRACTION_BITS : 34;
    localparam int QB     = (FRACTION_BITS < 18) ? 19 - FRACTION_BITS : 1;
    localparam int NP     = QB + CORDIC_STAGES + 2;
    localparam int SETUP  = QB + 1;
    localparam int HI_W   = XW - FIN_SPLIT;
    localparam int PH_W   = HI_W + GAIN_W;
    localparam int PL_W   = FIN_SPLIT + GAIN_W;
    localparam int MAG_W  = CLAMP_W - 1;

    localparam logic signed [ZW-1:0] HP_Z     = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] QR_Z     = ZW'(QUARTER_ROUND);
    localparam logic signed [ZW-1:0] ANG_RND  = ZW'(longint'(1) << (29 - FRACTION_BITS));
    localparam logic [PL_W:0]        FIN_RND  = (PL_W + 1)'(longint'(1) << (29 + GUARD_BITS));

    // pipeline state
    logic [NP+1:0]           vld_reg;
    logic [FUNC_W-1:0]       op_reg   [0:NP];
    logic signed [XW-1:0]    x_reg    [0:NP-1];
    logic signed [XW-1:0]    y_reg    [0:NP-1];
    logic signed [ZW-1:0]    z_reg    [0:NP-1];
    logic                    neg_reg  [0:QB];
    logic [QB-1:0]           q_reg    [0:QB];
    logic                    zero_reg [SETUP:NP-1];

    logic                    adv;

    // whole pipeline moves unless a result is stuck at the output
    assign adv        = !vld_reg[NP+1] || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NP:0], item.valid};
        end
    end

    // input stage: scale coordinates, form the angle magnitude for reduction
    logic signed [XW-1:0] ax_s, ay_s, bx_s, by_s;
    logic signed [XW-1:0] x_next, y_next;
    logic signed [ZW-1:0] ang_s, ang_mag, z_next;
    logic                 neg_next;

    always_comb
    begin
        ax_s     = {{(XW-VAL_W){item.a_x[VAL_W-1]}}, item.a_x};
        ay_s     = {{(XW-VAL_W){item.a_y[VAL_W-1]}}, item.a_y};
        bx_s     = {{(XW-VAL_W){item.b_x[VAL_W-1]}}, item.b_x};
        by_s     = {{(XW-VAL_W){item.b_y[VAL_W-1]}}, item.b_y};
        ang_s    = {{(ZW-ANG_W){item.turn_angle[ANG_W-1]}}, item.turn_angle} <<< ANG_SH;
        neg_next = ang_s[ZW-1];
        ang_mag  = neg_next ? -ang_s : ang_s;
        x_next   = '0;
        y_next   = '0;
        z_next   = '0;
        case (item.func)
            OP_SHIFT:
            begin
                x_next = ax_s + bx_s;
                y_next = ay_s + by_s;
            end
            OP_ROTATE:
            begin
                x_next = ax_s <<< GUARD_BITS;
                y_next = ay_s <<< GUARD_BITS;
                z_next = ang_mag + QR_Z;
            end
            OP_FROM_POLAR:
            begin
                x_next = ax_s <<< GUARD_BITS;
                z_next = ang_mag + QR_Z;
            end
            OP_TO_POLAR:
            begin
                x_next = ax_s <<< GUARD_BITS;
                y_next = ay_s <<< GUARD_BITS;
            end
            OP_DISTANCE:
            begin
                x_next = (ax_s - bx_s) <<< GUARD_BITS;
                y_next = (ay_s - by_s) <<< GUARD_BITS;
            end
            default:
            begin
                x_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]  <= item.func;
            x_reg[0]   <= x_next;
            y_reg[0]   <= y_next;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
            q_reg[0]   <= '0;
        end
    end

    // quarter-turn reduction, one restoring quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_reduce
        localparam int K = QB - 1 - j;
        localparam logic [ZW-1:0] THR = ZW'(HALF_PI_Q30 << K);

        logic                 ge;
        logic signed [ZW-1:0] r_next;
        logic [QB-1:0]        q_next;

        always_comb
        begin
            ge        = $unsigned(z_reg[j]) >= THR;
            r_next    = ge ? z_reg[j] - $signed(THR) : z_reg[j];
            q_next    = q_reg[j];
            q_next[K] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                op_reg[j+1]  <= op_reg[j];
                x_reg[j+1]   <= x_reg[j];
                y_reg[j+1]   <= y_reg[j];
                z_reg[j+1]   <= r_next;
                neg_reg[j+1] <= neg_reg[j];
                q_reg[j+1]   <= q_next;
            end
        end
    end

    // setup: exact quarter turns for rotation, half-plane fold for vectoring
    logic [1:0]           qq, qs;
    logic signed [XW-1:0] sx, sy, sx_next, sy_next;
    logic signed [ZW-1:0] sz, sz_next;
    logic                 zero_next;

    always_comb
    begin
        sx        = x_reg[QB];
        sy        = y_reg[QB];
        sz        = z_reg[QB];
        qq        = 2'(q_reg[QB]);
        qs        = neg_reg[QB] ? 2'(2'd0 - qq) : qq;
        sx_next   = sx;
        sy_next   = sy;
        sz_next   = sz;
        zero_next = 1'b0;
        case (op_reg[QB])
            OP_ROTATE, OP_FROM_POLAR:
            begin
                sz_next = neg_reg[QB] ? QR_Z - sz : sz - QR_Z;
                case (qs)
                    2'd1:
                    begin
                        sx_next = -sy;
                        sy_next = sx;
                    end
                    2'd2:
                    begin
                        sx_next = -sx;
                        sy_next = -sy;
                    end
                    2'd3:
                    begin
                        sx_next = sy;
                        sy_next = -sx;
                    end
                    default:
                    begin
                        sx_next = sx;
                    end
                endcase
            end
            OP_TO_POLAR, OP_DISTANCE:
            begin
                zero_next = (sx == 0) && (sy == 0);
                sz_next   = '0;
                if (sx < 0)
                begin
                    if (sy >= 0)
                    begin
                        sx_next = sy;
                        sy_next = -sx;
                        sz_next = HP_Z;
                    end
                    else
                    begin
                        sx_next = -sy;
                        sy_next = sx;
                        sz_next = -HP_Z;
                    end
                end
            end
            default:
            begin
                sz_next = sz;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[SETUP]   <= op_reg[QB];
            x_reg[SETUP]    <= sx_next;
            y_reg[SETUP]    <= sy_next;
            z_reg[SETUP]    <= sz_next;
            zero_reg[SETUP] <= zero_next;
        end
    end

    // cordic micro-rotations, one per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        localparam int P = SETUP + i;
        localparam logic signed [ZW-1:0] AT = ZW'(atan_q30(i));

        logic                 rot, vec, ccw;
        logic signed [XW-1:0] dx, dy, cx_next, cy_next;
        logic signed [ZW-1:0] cz_next;

        always_comb
        begin
            rot     = (op_reg[P] == OP_ROTATE) || (op_reg[P] == OP_FROM_POLAR);
            vec     = (op_reg[P] == OP_TO_POLAR) || (op_reg[P] == OP_DISTANCE);
            ccw     = rot ? !z_reg[P][ZW-1] : (y_reg[P] <= 0);
            dx      = y_reg[P] >>> i;
            dy      = x_reg[P] >>> i;
            cx_next = x_reg[P];
            cy_next = y_reg[P];
            cz_next = z_reg[P];
            if (rot || vec)
            begin
                if (ccw)
                begin
                    cx_next = x_reg[P] - dx;
                    cy_next = y_reg[P] + dy;
                    cz_next = z_reg[P] - AT;
                end
                else
                begin
                    cx_next = x_reg[P] + dx;
                    cy_next = y_reg[P] - dy;
                    cz_next = z_reg[P] + AT;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                op_reg[P+1]   <= op_reg[P];
                x_reg[P+1]    <= cx_next;
                y_reg[P+1]    <= cy_next;
                z_reg[P+1]    <= cz_next;
                zero_reg[P+1] <= zero_reg[P];
            end
        end
    end

    // gain multiply in two partial products per coordinate, angle rounding, shift clamp
    logic [XW-1:0]        mx, my;
    logic                 fsx_next, fsy_next;
    logic signed [ZW-1:0] zr;
    logic [VAL_W-1:0]     ang_next;
    logic [VAL_W:0]       px_c, py_c;

    logic                 fsx_reg, fsy_reg;
    logic [PH_W-1:0]      phx_reg, phy_reg;
    logic [PL_W-1:0]      plx_reg, ply_reg;
    logic [VAL_W-1:0]     ang_reg;
    logic [VAL_W-1:0]     passx_reg, passy_reg;
    logic                 pass_sat_reg;

    always_comb
    begin
        fsx_next = x_reg[NP-1][XW-1];
        fsy_next = y_reg[NP-1][XW-1];
        mx       = fsx_next ? $unsigned(-x_reg[NP-1]) : $unsigned(x_reg[NP-1]);
        my       = fsy_next ? $unsigned(-y_reg[NP-1]) : $unsigned(y_reg[NP-1]);
        zr       = (z_reg[NP-1] + ANG_RND) >>> ANG_SH;
        ang_next = zero_reg[NP-1] ? '0 : zr[VAL_W-1:0];
        px_c     = clamp_val(x_reg[NP-1][CLAMP_W-1:0]);
        py_c     = clamp_val(y_reg[NP-1][CLAMP_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[NP]   <= op_reg[NP-1];
            fsx_reg      <= fsx_next;
            fsy_reg      <= fsy_next;
            phx_reg      <= mx[XW-1:FIN_SPLIT] * GAIN_Q30;
            plx_reg      <= mx[FIN_SPLIT-1:0] * GAIN_Q30;
            phy_reg      <= my[XW-1:FIN_SPLIT] * GAIN_Q30;
            ply_reg      <= my[FIN_SPLIT-1:0] * GAIN_Q30;
            ang_reg      <= ang_next;
            passx_reg    <= px_c[VAL_W-1:0];
            passy_reg    <= py_c[VAL_W-1:0];
            pass_sat_reg <= px_c[VAL_W] | py_c[VAL_W];
        end
    end

    // final rounding, sign, clamp and result select
    logic [PL_W:0]              lx_sum, ly_sum;
    logic [PH_W-1:0]            hx_sum, hy_sum;
    logic [MAG_W-1:0]           magx, magy;
    logic signed [CLAMP_W-1:0]  vx, vy;
    logic [VAL_W:0]             cx, cy;
    logic [VAL_W-1:0]           ox_next, oy_next;
    logic                       sat_next;

    logic [VAL_W-1:0]           out_x_reg, out_y_reg;
    logic                       sat_reg;

    always_comb
    begin
        lx_sum  = {1'b0, plx_reg} + FIN_RND;
        ly_sum  = {1'b0, ply_reg} + FIN_RND;
        hx_sum  = phx_reg + PH_W'(lx_sum >> FIN_SPLIT);
        hy_sum  = phy_reg + PH_W'(ly_sum >> FIN_SPLIT);
        magx    = MAG_W'(hx_sum >> FIN_SHIFT);
        magy    = MAG_W'(hy_sum >> FIN_SHIFT);
        vx      = {1'b0, magx};
        vy      = {1'b0, magy};
        if (fsx_reg)
        begin
            vx = -vx;
        end
        if (fsy_reg)
        begin
            vy = -vy;
        end
        cx      = clamp_val(vx);
        cy      = clamp_val(vy);
        ox_next = '0;
        oy_next = '0;
        sat_next = 1'b0;
        case (op_reg[NP])
            OP_SHIFT:
            begin
                ox_next  = passx_reg;
                oy_next  = passy_reg;
                sat_next = pass_sat_reg;
            end
            OP_ROTATE, OP_FROM_POLAR:
            begin
                ox_next  = cx[VAL_W-1:0];
                oy_next  = cy[VAL_W-1:0];
                sat_next = cx[VAL_W] | cy[VAL_W];
            end
            OP_TO_POLAR:
            begin
                ox_next  = cx[VAL_W-1:0];
                oy_next  = ang_reg;
                sat_next = cx[VAL_W];
            end
            OP_DISTANCE:
            begin
                ox_next  = cx[VAL_W-1:0];
                sat_next = cx[VAL_W];
            end
            default:
            begin
                ox_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg <= ox_next;
            out_y_reg <= oy_next;
            sat_reg   <= sat_next;
        end
    end

    assign result.valid     = vld_reg[NP+1];
    assign result.out_x     = out_x_reg;
    assign result.out_y     = out_y_reg;
    assign result.saturated = sat_reg;

    // a result left waiting blocks intake
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !item.ready)
        else $error("intake open while a result was left waiting");

    // reduced rotation angle stays within a half quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SETUP] && (op_reg[SETUP] == OP_ROTATE || op_reg[SETUP] == OP_FROM_POLAR)
        |-> (z_reg[SETUP] <= QR_Z + 1) && (z_reg[SETUP] >= -QR_Z))
        else $error("angle reduction left too large a remainder");

    // vectoring starts in the right half plane
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SETUP] && (op_reg[SETUP] == OP_TO_POLAR || op_reg[SETUP] == OP_DISTANCE)
        |-> !x_reg[SETUP][XW-1])
        else $error("vectoring fold left x negative");

    // a zero vector stays zero through the micro-rotations
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NP-1] && zero_reg[NP-1] |-> (x_reg[NP-1] == 0) && (y_reg[NP-1] == 0))
        else $error("zero vector picked up a magnitude");

endmodule

/* test/pcc_result_checker.sv */
`timescale 1ns / 100ps

// watches both channels, predicts each result and compares it with the block
module pcc_result_checker
    import pcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pcc_in_if    item,
    pcc_out_if   result,
    output int   mismatch_count,
    output int   pending_count
);

    localparam int          STAGES       = CORDIC_STAGES_DEF;
    localparam int          FRAC         = FRACTION_BITS_DEF;
    localparam int          COORD_GUARD  = 8;
    localparam longint      QUARTER_TURN = 64'sd1686629713;
    localparam bit [63:0]   CORDIC_GAIN  = 64'h26DD3B6A;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic                    sat;
    } point_result_t;

    point_result_t expected_points[$];
    point_result_t oldest;

    // atan(2^-i) in q30
    function automatic longint atan_step(input int i);
        longint a;
        case (i)
            0:  a = 64'h3243F6A8;
            1:  a = 64'h1DAC6705;
            2:  a = 64'h0FADBAFC;
            3:  a = 64'h07F56EA6;
            4:  a = 64'h03FEAB76;
            5:  a = 64'h01FFD55B;
            6:  a = 64'h00FFFAAA;
            7:  a = 64'h007FFF55;
            8:  a = 64'h003FFFEA;
            9:  a = 64'h001FFFFD;
            10: a = 64'h000FFFFF;
            11: a = 64'h0007FFFF;
            12: a = 64'h0003FFFF;
            13: a = 64'h0001FFFF;
            14: a = 64'h0000FFFF;
            15: a = 64'h00007FFF;
            16: a = 64'h00003FFF;
            17: a = 64'h00001FFF;
            18: a = 64'h00000FFF;
            19: a = 64'h000007FF;
            20: a = 64'h000003FF;
            21: a = 64'h000001FF;
            22: a = 64'h000000FF;
            23: a = 64'h0000007F;
            24: a = 64'h0000003F;
            25: a = 64'h0000001F;
            26: a = 64'h0000000F;
            27: a = 64'h00000008;
            28: a = 64'h00000004;
            29: a = 64'h00000002;
            30: a = 64'h00000001;
            default: a = 0;
        endcase
        return a;
    endfunction

    function automatic longint clamp_to_word(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // magnitude times the gain, rounded half away from zero, then clamped
    function automatic longint scale_by_gain(input longint v, inout bit sat);
        bit [63:0] m;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] r;
        longint    s;
        if (v < 0)
        begin
            m = -v;
        end
        else
        begin
            m = v;
        end
        hi = (m >> 21) * CORDIC_GAIN;
        lo = (m & 64'h1F_FFFF) * CORDIC_GAIN + (64'd1 << (29 + COORD_GUARD));
        r = (hi + (lo >> 21)) >> (30 + COORD_GUARD - 21);
        s = r;
        if (v < 0)
        begin
            s = -s;
        end
        return clamp_to_word(s, sat);
    endfunction

    // quarter-turn reduction, then rotation mode stages
    function automatic void rotate_vector(inout longint x, inout longint y, input longint z);
        longint q;
        longint t;
        longint dx;
        longint dy;
        if (z >= 0)
        begin
            q = (z + QUARTER_TURN / 2) / QUARTER_TURN;
        end
        else
        begin
            q = -((-z + QUARTER_TURN / 2) / QUARTER_TURN);
        end
        z = z - q * QUARTER_TURN;
        case (q[1:0])
            2'd1:
            begin
                t = x;
                x = -y;
                y = t;
            end
            2'd2:
            begin
                x = -x;
                y = -y;
            end
            2'd3:
            begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
    endfunction

    // vectoring mode, returns the unscaled magnitude and the q30 angle
    function automatic longint vector_magnitude(input longint x, input longint y,
                                                output longint z);
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return x;
    endfunction

    function automatic point_result_t predict_point_op(
        input logic [FUNC_W-1:0] op,
        input longint ax, input longint ay, input longint bx, input longint by,
        input longint ang
    );
        point_result_t r;
        longint        x;
        longint        y;
        longint        z;
        longint        mag;
        longint        rx;
        longint        ry;
        bit            sat;
        rx = 0;
        ry = 0;
        sat = 1'b0;
        case (op)
            OP_SHIFT:
            begin
                rx = clamp_to_word(ax + bx, sat);
                ry = clamp_to_word(ay + by, sat);
            end
            OP_ROTATE, OP_FROM_POLAR:
            begin
                x = ax <<< COORD_GUARD;
                y = (op == OP_ROTATE) ? (ay <<< COORD_GUARD) : 0;
                rotate_vector(x, y, ang <<< (30 - FRAC));
                rx = scale_by_gain(x, sat);
                ry = scale_by_gain(y, sat);
            end
            OP_TO_POLAR:
            begin
                mag = vector_magnitude(ax <<< COORD_GUARD, ay <<< COORD_GUARD, z);
                rx = scale_by_gain(mag, sat);
                ry = (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
            end
            OP_DISTANCE:
            begin
                mag = vector_magnitude((ax - bx) <<< COORD_GUARD,
                                       (ay - by) <<< COORD_GUARD, z);
                rx = scale_by_gain(mag, sat);
            end
            default: ;
        endcase
        r.x = rx[VAL_W-1:0];
        r.y = ry[VAL_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_count = 0;
    end

    // results are compared before new transactions are queued in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: out_x %0d out_y %0d saturated %0b",
                           result.out_x, result.out_y, result.saturated);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_points.pop_front();
                    if (oldest.x !== result.out_x)
                    begin
                        $error("out_x: expected %0d, actual %0d", oldest.x, result.out_x);
                        mismatch_count++;
                    end
                    if (oldest.y !== result.out_y)
                    begin
                        $error("out_y: expected %0d, actual %0d", oldest.y, result.out_y);
                        mismatch_count++;
                    end
                    if (oldest.sat !== result.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               oldest.sat, result.saturated);
                        mismatch_count++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                expected_points.push_back(predict_point_op(item.func, item.a_x, item.a_y,
                                                           item.b_x, item.b_y,
                                                           item.turn_angle));
            end
            pending_count = expected_points.size();
        end
    end

endmodule

/* test/planar_coordinate_cordic_tb.sv */
`timescale 1ns / 100ps

module planar_coordinate_cordic_tb;
    import pcc_pkg::*;

    localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh80000000;
    localparam logic signed [VAL_W-1:0] ONE_Q    = 32'sd65536;
    localparam logic signed [ANG_W-1:0] ANG_PI        = 19'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI   = 19'sd102944;
    localparam logic signed [ANG_W-1:0] ANG_FIELD_MAX = 19'sh3FFFF;
    localparam logic signed [ANG_W-1:0] ANG_FIELD_MIN = 19'sh40000;
    localparam logic [FUNC_W-1:0] OP_CODE_MAX = {FUNC_W{1'b1}};

    localparam int RX_HOLD_CYCLES = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;
    bit   tx_idle_en;
    bit   rx_idle_en;
    bit   rx_hold_req;
    int   check_fails;
    int   results_pending;
    int   stall_cycles;

    pcc_in_if  item_if();
    pcc_out_if result_if();

    planar_coordinate_cordic uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    pcc_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_if),
        .result         (result_if),
        .mismatch_count (check_fails),
        .pending_count  (results_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (item_if.valid && item_if.ready)
                || (result_if.valid && result_if.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("planar_coordinate_cordic_tb: FAIL");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_coord();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2: v = $urandom;
            3, 4, 5: v = $signed($urandom) >>> $urandom_range(12, 26);
            default: v = $signed($urandom) >>> $urandom_range(0, 11);
        endcase
        return v;
    endfunction

    function automatic logic [FUNC_W-1:0] rand_op();
        logic [FUNC_W-1:0] op;
        case ($urandom_range(0, 20))
            0, 1, 2, 3:     op = OP_SHIFT;
            4, 5, 6, 7:     op = OP_ROTATE;
            8, 9, 10, 11:   op = OP_TO_POLAR;
            12, 13, 14, 15: op = OP_FROM_POLAR;
            16, 17, 18, 19: op = OP_DISTANCE;
            default:        op = FUNC_W'($urandom_range(OP_DISTANCE + 1, OP_CODE_MAX));
        endcase
        return op;
    endfunction

    // offer one transaction, starting and ending at a falling edge
    task automatic send_op(input logic [FUNC_W-1:0] op,
                           input logic signed [VAL_W-1:0] ax, input logic signed [VAL_W-1:0] ay,
                           input logic signed [VAL_W-1:0] bx, input logic signed [VAL_W-1:0] by,
                           input logic signed [ANG_W-1:0] ang);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_if.func       <= op;
        item_if.a_x        <= ax;
        item_if.a_y        <= ay;
        item_if.b_x        <= bx;
        item_if.b_y        <= by;
        item_if.turn_angle <= ang;
        item_if.valid      <= 1'b1;
        @(posedge clk);
        while (!item_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_random_ops(input int count);
        logic [FUNC_W-1:0]       op;
        logic signed [VAL_W-1:0] ax;
        logic signed [VAL_W-1:0] ay;
        logic signed [VAL_W-1:0] bx;
        logic signed [VAL_W-1:0] by;
        logic signed [ANG_W-1:0] ang;
        repeat (count)
        begin
            op = rand_op();
            ax = rand_coord();
            ay = rand_coord();
            bx = rand_coord();
            by = rand_coord();
            // nearby points for distance now and then
            if (op == OP_DISTANCE && $urandom_range(0, 2) == 0)
            begin
                bx = ax + ($signed($urandom) >>> 18);
                by = ay + ($signed($urandom) >>> 18);
            end
            if ($urandom_range(0, 7) != 0)
            begin
                ang = ANG_W'(int'($urandom_range(0, 2 * int'(ANG_PI))) - int'(ANG_PI));
            end
            else
            begin
                ang = ANG_W'($urandom);
            end
            send_op(op, ax, ay, bx, by, ang);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_req = 1'b0;
        item_if.valid = 1'b0;
        item_if.func = OP_SHIFT;
        item_if.a_x = '0;
        item_if.a_y = '0;
        item_if.b_x = '0;
        item_if.b_y = '0;
        item_if.turn_angle = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // shift, including saturation on each side
        send_op(OP_SHIFT, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, -4 * ONE_Q, 0);
        send_op(OP_SHIFT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 0);
        send_op(OP_SHIFT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0);
        send_op(OP_SHIFT, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 0);
        // rotate, across the quarter-turn reduction and beyond pi
        send_op(OP_ROTATE, ONE_Q, 0, 0, 0, 0);
        send_op(OP_ROTATE, ONE_Q, ONE_Q, 0, 0, ANG_PI);
        send_op(OP_ROTATE, 3 * ONE_Q, -2 * ONE_Q, 0, 0, -ANG_PI);
        send_op(OP_ROTATE, WORD_MAX, WORD_MAX, 0, 0, ANG_W'(ANG_HALF_PI / 2));
        send_op(OP_ROTATE, WORD_MIN, WORD_MIN, 0, 0, ANG_FIELD_MAX);
        send_op(OP_ROTATE, -5 * ONE_Q, 7 * ONE_Q, 0, 0, ANG_FIELD_MIN);
        // to polar: zero vector, negative x on both sides, extremes
        send_op(OP_TO_POLAR, 0, 0, 0, 0, 0);
        send_op(OP_TO_POLAR, -3 * ONE_Q, 4 * ONE_Q, 0, 0, 0);
        send_op(OP_TO_POLAR, -3 * ONE_Q, -4 * ONE_Q, 0, 0, 0);
        send_op(OP_TO_POLAR, 0, -ONE_Q, 0, 0, 0);
        send_op(OP_TO_POLAR, WORD_MAX, WORD_MAX, 0, 0, 0);
        send_op(OP_TO_POLAR, WORD_MIN, 0, 0, 0, 0);
        // from polar, negative distance and ignored y
        send_op(OP_FROM_POLAR, 10 * ONE_Q, 0, 0, 0, ANG_HALF_PI);
        send_op(OP_FROM_POLAR, -10 * ONE_Q, WORD_MAX, 0, 0, 19'sd12345);
        send_op(OP_FROM_POLAR, WORD_MIN, WORD_MIN, 0, 0, 0);
        // distance: zero vector, saturating span, plain case
        send_op(OP_DISTANCE, 5 * ONE_Q, -ONE_Q, 5 * ONE_Q, -ONE_Q, ANG_PI);
        send_op(OP_DISTANCE, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, 0);
        send_op(OP_DISTANCE, ONE_Q, 2 * ONE_Q, 4 * ONE_Q, 6 * ONE_Q, 0);
        // undefined operation codes
        send_op(FUNC_W'(OP_DISTANCE + 1), WORD_MAX, WORD_MIN, ONE_Q, ONE_Q, ANG_PI);
        send_op(FUNC_W'(OP_DISTANCE + 2), ONE_Q, ONE_Q, WORD_MAX, WORD_MIN, ANG_HALF_PI);
        send_op(OP_CODE_MAX, -1, -1, -1, -1, ANG_FIELD_MIN);

        // sender pauses until the pipeline has drained
        item_if.valid <= 1'b0;
        wait (results_pending == 0);
        @(negedge clk);

        send_random_ops(400);

        // long hold-off on the result side while transactions keep coming
        tx_idle_en = 1'b0;
        rx_hold_req = 1'b1;
        send_random_ops(200);
        tx_idle_en = 1'b1;

        send_random_ops(200);

        // final stretch with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_ops(150);

        item_if.valid <= 1'b0;
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_fails == 0 && results_pending == 0)
        begin
            $display("planar_coordinate_cordic_tb: PASS");
        end
        else
        begin
            $display("planar_coordinate_cordic_tb: FAIL");
        end
        $finish;
    end

endmodule
